// ===== rtl/usb_setup_request_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// USB setup request classifier: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef USB_SETUP_REQUEST_CLASSIFIER_DEFINES_SVH
`define USB_SETUP_REQUEST_CLASSIFIER_DEFINES_SVH

// Same-cycle implication
`define USRC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define USRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/usrc_pkg.sv =====
// ----------------------------------------------------------------------------
// USB setup request classifier: package
// Request codes, result kinds, register indexes and shared structs.
// ----------------------------------------------------------------------------
package usrc_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_ENDPOINT_LIMIT  = 2'd0;
	localparam logic [1:0] CFG_INTERFACE_LIMIT = 2'd1;
	localparam logic [1:0] CFG_VENDOR_CODE     = 2'd2;
	localparam logic [1:0] CFG_VENDOR_INDEX    = 2'd3;

	// Request type field (bits 6-5)
	localparam logic [1:0] TYPE_STANDARD = 2'd0;
	localparam logic [1:0] TYPE_CLASS    = 2'd1;
	localparam logic [1:0] TYPE_VENDOR   = 2'd2;

	// Full request type bytes checked exactly
	localparam logic [7:0] RT_DEV_OUT    = 8'h00;
	localparam logic [7:0] RT_DEV_IN     = 8'h80;
	localparam logic [7:0] RT_INTF_OUT   = 8'h01;
	localparam logic [7:0] RT_INTF_IN    = 8'h81;
	localparam logic [7:0] RT_EP_OUT     = 8'h02;
	localparam logic [7:0] RT_VENDOR_IN  = 8'hc0;

	localparam logic [4:0]  RECIP_DEVICE    = 5'd0;
	localparam logic [4:0]  RECIP_INTERFACE = 5'd1;
	localparam logic [15:0] EP_RESERVED_MASK = 16'hff70;
	localparam logic [15:0] MAX_ADDRESS      = 16'd127;
	localparam logic [15:0] FEATURE_REMOTE_WAKEUP = 16'd1;
	localparam logic [15:0] CDC_MAX_ENCAP_LEN     = 16'd64;
	localparam logic [15:0] LINE_CODING_LEN       = 16'd7;

	// Standard request codes
	localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
	localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
	localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
	localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
	localparam logic [7:0] REQ_GET_DESC      = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
	localparam logic [7:0] REQ_GET_INTF      = 8'h0a;
	localparam logic [7:0] REQ_SET_INTF      = 8'h0b;

	// HID class request codes
	localparam logic [7:0] HID_GET_REPORT   = 8'h01;
	localparam logic [7:0] HID_GET_IDLE     = 8'h02;
	localparam logic [7:0] HID_GET_PROTOCOL = 8'h03;
	localparam logic [7:0] HID_SET_REPORT   = 8'h09;
	localparam logic [7:0] HID_SET_IDLE     = 8'h0a;
	localparam logic [7:0] HID_SET_PROTOCOL = 8'h0b;

	// CDC class request codes
	localparam logic [7:0] CDC_SEND_ENCAP     = 8'h00;
	localparam logic [7:0] CDC_GET_ENCAP      = 8'h01;
	localparam logic [7:0] CDC_SET_LINE_CODE  = 8'h20;
	localparam logic [7:0] CDC_GET_LINE_CODE  = 8'h21;
	localparam logic [7:0] CDC_SET_LINE_STATE = 8'h22;

	// Result kinds
	localparam logic [4:0] KIND_NONE           = 5'd0;
	localparam logic [4:0] KIND_GET_STATUS     = 5'd1;
	localparam logic [4:0] KIND_CLEAR_FEATURE  = 5'd2;
	localparam logic [4:0] KIND_SET_FEATURE    = 5'd3;
	localparam logic [4:0] KIND_SET_ADDRESS    = 5'd4;
	localparam logic [4:0] KIND_GET_DESC       = 5'd5;
	localparam logic [4:0] KIND_GET_CONFIG     = 5'd6;
	localparam logic [4:0] KIND_SET_CONFIG     = 5'd7;
	localparam logic [4:0] KIND_GET_INTF       = 5'd8;
	localparam logic [4:0] KIND_SET_INTF       = 5'd9;
	localparam logic [4:0] KIND_HID_GET_REPORT = 5'd10;
	localparam logic [4:0] KIND_HID_GET_IDLE   = 5'd11;
	localparam logic [4:0] KIND_HID_GET_PROTO  = 5'd12;
	localparam logic [4:0] KIND_HID_SET_REPORT = 5'd13;
	localparam logic [4:0] KIND_HID_SET_IDLE   = 5'd14;
	localparam logic [4:0] KIND_HID_SET_PROTO  = 5'd15;
	localparam logic [4:0] KIND_CDC_SEND_ENCAP = 5'd16;
	localparam logic [4:0] KIND_CDC_GET_ENCAP  = 5'd17;
	localparam logic [4:0] KIND_CDC_SET_LINE   = 5'd18;
	localparam logic [4:0] KIND_CDC_GET_LINE   = 5'd19;
	localparam logic [4:0] KIND_CDC_SET_STATE  = 5'd20;
	localparam logic [4:0] KIND_VENDOR_SEC     = 5'd21;

	// Register reset values
	localparam logic [4:0]  RST_ENDPOINT_LIMIT  = 5'd5;
	localparam logic [7:0]  RST_INTERFACE_LIMIT = 8'd2;
	localparam logic [7:0]  RST_VENDOR_CODE     = 8'h90;
	localparam logic [15:0] RST_VENDOR_INDEX    = 16'd4;

	typedef struct packed {
		logic [4:0]  endpoint_limit;
		logic [7:0]  interface_limit;
		logic [7:0]  vendor_request_code;
		logic [15:0] vendor_index_match;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  setup_type;
		logic [7:0]  request_code;
		logic [15:0] setup_value;
		logic [15:0] setup_index;
		logic [15:0] setup_length;
	} setup_t;

	typedef struct packed {
		logic        supported;
		logic [4:0]  kind;
		logic [4:0]  recipient;
		logic [7:0]  desc_code;
		logic [7:0]  descriptor_number;
		logic [15:0] value_out;
		logic [15:0] index_out;
		logic [15:0] length_out;
	} result_t;

endpackage

// ===== rtl/usrc_decode.sv =====
// ----------------------------------------------------------------------------
// USB setup request classifier: request decoder
// Matches one setup packet against the supported standard, CDC, HID and
// vendor forms and builds the result, zeroed when nothing matches.
// ----------------------------------------------------------------------------
module usrc_decode (
	input  usrc_pkg::cfg_t    cfg,
	input  usrc_pkg::setup_t  setup,
	output usrc_pkg::result_t result
);
	import usrc_pkg::*;

	logic [7:0]  rt;
	logic [7:0]  rq;
	logic [15:0] v;
	logic [15:0] ix;
	logic [15:0] len;
	logic        dir_in;
	logic [4:0]  rc;
	logic [3:0]  ep;
	logic        ix_below_intf;
	logic        feat_dev;
	logic        feat_halt;
	logic [4:0]  std_kind;
	logic [4:0]  cdc_kind;
	logic [4:0]  hid_kind;
	logic [4:0]  kind;

	assign rt     = setup.setup_type;
	assign rq     = setup.request_code;
	assign v      = setup.setup_value;
	assign ix     = setup.setup_index;
	assign len    = setup.setup_length;
	assign dir_in = rt[7];
	assign rc     = rt[4:0];
	assign ep     = ix[3:0];

	assign ix_below_intf = ix < {8'd0, cfg.interface_limit};
	assign feat_dev  = (rt == RT_DEV_OUT) && (v == FEATURE_REMOTE_WAKEUP) && (ix == '0);
	assign feat_halt = (rt == RT_EP_OUT) && (v == '0) && ((ix & EP_RESERVED_MASK) == '0)
		&& (ep != '0) && ({1'b0, ep} < cfg.endpoint_limit);

	// Decode standard requests
	always_comb begin
		std_kind = KIND_NONE;
		unique case (rq) inside
			REQ_GET_STATUS: begin
				if (dir_in && v == '0 && len == 16'd2) std_kind = KIND_GET_STATUS;
			end
			REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
				if (len == '0 && (feat_dev || feat_halt))
					std_kind = (rq == REQ_SET_FEATURE) ? KIND_SET_FEATURE : KIND_CLEAR_FEATURE;
			end
			REQ_SET_ADDRESS: begin
				if (rt == RT_DEV_OUT && v <= MAX_ADDRESS && ix == '0 && len == '0)
					std_kind = KIND_SET_ADDRESS;
			end
			REQ_GET_DESC: begin
				if (dir_in && len != '0 && (rc == RECIP_DEVICE || rc == RECIP_INTERFACE))
					std_kind = KIND_GET_DESC;
			end
			REQ_GET_CONFIG: begin
				if (rt == RT_DEV_IN && v == '0 && ix == '0 && len == 16'd1)
					std_kind = KIND_GET_CONFIG;
			end
			REQ_SET_CONFIG: begin
				if (rt == RT_DEV_OUT && ix == '0 && len == '0) std_kind = KIND_SET_CONFIG;
			end
			REQ_GET_INTF: begin
				if (rt == RT_INTF_IN && v == '0 && ix_below_intf && len == 16'd1)
					std_kind = KIND_GET_INTF;
			end
			REQ_SET_INTF: begin
				if (rt == RT_INTF_OUT && ix_below_intf && len == '0) std_kind = KIND_SET_INTF;
			end
			default: std_kind = KIND_NONE;
		endcase
	end

	// Decode CDC class requests
	always_comb begin
		cdc_kind = KIND_NONE;
		if (rc == RECIP_INTERFACE && ix <= 16'd1 && (v == '0 || rq == CDC_SET_LINE_STATE)) begin
			unique case (rq)
				CDC_SEND_ENCAP: begin
					if (!dir_in && len <= CDC_MAX_ENCAP_LEN) cdc_kind = KIND_CDC_SEND_ENCAP;
				end
				CDC_GET_ENCAP: begin
					if (dir_in) cdc_kind = KIND_CDC_GET_ENCAP;
				end
				CDC_SET_LINE_CODE: begin
					if (!dir_in && len == LINE_CODING_LEN) cdc_kind = KIND_CDC_SET_LINE;
				end
				CDC_GET_LINE_CODE: begin
					if (dir_in && len == LINE_CODING_LEN) cdc_kind = KIND_CDC_GET_LINE;
				end
				CDC_SET_LINE_STATE: begin
					if (!dir_in && len == '0) cdc_kind = KIND_CDC_SET_STATE;
				end
				default: cdc_kind = KIND_NONE;
			endcase
		end
	end

	// Decode HID class requests
	always_comb begin
		hid_kind = KIND_NONE;
		if (rc == RECIP_INTERFACE && ix == '0) begin
			unique case (rq)
				HID_GET_REPORT: begin
					if (dir_in && len != '0) hid_kind = KIND_HID_GET_REPORT;
				end
				HID_GET_IDLE: begin
					if (dir_in && len == 16'd1) hid_kind = KIND_HID_GET_IDLE;
				end
				HID_GET_PROTOCOL: begin
					if (dir_in && v == '0 && len == 16'd1) hid_kind = KIND_HID_GET_PROTO;
				end
				HID_SET_REPORT: begin
					if (!dir_in && len != '0) hid_kind = KIND_HID_SET_REPORT;
				end
				HID_SET_IDLE: begin
					if (!dir_in && len == '0) hid_kind = KIND_HID_SET_IDLE;
				end
				HID_SET_PROTOCOL: begin
					if (!dir_in && len == '0) hid_kind = KIND_HID_SET_PROTO;
				end
				default: hid_kind = KIND_NONE;
			endcase
		end
	end

	// Select by request type; CDC wins over HID
	always_comb begin
		unique case (rt[6:5])
			TYPE_STANDARD: kind = std_kind;
			TYPE_CLASS:    kind = (cdc_kind != KIND_NONE) ? cdc_kind : hid_kind;
			TYPE_VENDOR: begin
				kind = (rt == RT_VENDOR_IN && rq == cfg.vendor_request_code
					&& ix == cfg.vendor_index_match) ? KIND_VENDOR_SEC : KIND_NONE;
			end
			default:       kind = KIND_NONE;
		endcase
	end

	// Build the result, all zero when unsupported
	always_comb begin
		result = '0;
		if (kind != KIND_NONE) begin
			result.supported         = 1'b1;
			result.kind              = kind;
			result.recipient         = rc;
			result.desc_code         = v[15:8];
			result.descriptor_number = v[7:0];
			result.value_out         = v;
			result.index_out         = ix;
			result.length_out        = len;
		end
	end

endmodule

// ===== rtl/usb_setup_request_classifier.sv =====
// ----------------------------------------------------------------------------
// USB setup request classifier
// Classifies decoded USB control setup packets against a supported subset
// of standard, CDC, HID and vendor requests; one result per packet.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    setup_type .. setup_length
//   out      output     out_valid/out_ready  supported .. length_out
//   cfg      input      cfg_we (no wait)     cfg_index, cfg_data
//
// One packet per cycle sustained while out_ready stays high; an accepted packet
// passes the input register, decode and result register before out_valid rises.
// Reset clears both stage valid flags and loads the register defaults.
// A stalled output holds its result; the input stage accepts while it is
// empty or while the result register is empty or draining.
// ----------------------------------------------------------------------------
`include "usb_setup_request_classifier_defines.svh"

module usb_setup_request_classifier (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// setup packet channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  setup_type,
	input  logic [7:0]  request_code,
	input  logic [15:0] setup_value,
	input  logic [15:0] setup_index,
	input  logic [15:0] setup_length,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        supported,
	output logic [4:0]  kind,
	output logic [4:0]  recipient,
	output logic [7:0]  desc_code,
	output logic [7:0]  descriptor_number,
	output logic [15:0] value_out,
	output logic [15:0] index_out,
	output logic [15:0] length_out
);
	import usrc_pkg::*;

	cfg_t    cfg_q;
	setup_t  setup_s1;
	logic    valid_s1;
	result_t result_comb;
	result_t result_s2;
	logic    valid_s2;
	logic    adv_s2;
	logic    adv_s1;
	logic    in_fire;
	logic    unsup_zero;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.endpoint_limit      <= RST_ENDPOINT_LIMIT;
			cfg_q.interface_limit     <= RST_INTERFACE_LIMIT;
			cfg_q.vendor_request_code <= RST_VENDOR_CODE;
			cfg_q.vendor_index_match  <= RST_VENDOR_INDEX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENDPOINT_LIMIT:  cfg_q.endpoint_limit      <= cfg_data[4:0];
				CFG_INTERFACE_LIMIT: cfg_q.interface_limit     <= cfg_data[7:0];
				CFG_VENDOR_CODE:     cfg_q.vendor_request_code <= cfg_data[7:0];
				CFG_VENDOR_INDEX:    cfg_q.vendor_index_match  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign in_fire  = in_valid && in_ready;

	// Input stage: capture the packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			setup_s1 <= '{setup_type: setup_type, request_code: request_code,
				setup_value: setup_value, setup_index: setup_index,
				setup_length: setup_length};
		end
	end

	usrc_decode u_decode (
		.cfg    (cfg_q),
		.setup  (setup_s1),
		.result (result_comb)
	);

	// Result stage: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_comb;
		end
	end

	assign out_valid         = valid_s2;
	assign supported         = result_s2.supported;
	assign kind              = result_s2.kind;
	assign recipient         = result_s2.recipient;
	assign desc_code         = result_s2.desc_code;
	assign descriptor_number = result_s2.descriptor_number;
	assign value_out         = result_s2.value_out;
	assign index_out         = result_s2.index_out;
	assign length_out        = result_s2.length_out;

	// Checks
	assign unsup_zero = {recipient, desc_code, descriptor_number, value_out, index_out,
		length_out} == '0;

	`USRC_ASSERT_SAME(a_supported_kind, valid_s2, supported == (kind != KIND_NONE), "bad flag")
	`USRC_ASSERT_SAME(a_unsupported_zero, valid_s2 && !supported, unsup_zero, "not zeroed")
	`USRC_ASSERT_NEXT(a_accept_lands, in_fire, valid_s1, "accepted packet lost")
	`USRC_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv_s2, valid_s1 && $stable(setup_s1), "s1 moved")

endmodule
